FILE: src/rlmg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmg_pkg
// Shared constants, types and the root-of-two table for the loudness
// matching gain block.
// ----------------------------------------------------------------------------
package rlmg_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int BLOCK_MAX   = 64;
    localparam int CNT_W       = 7;
    localparam int ADDR_W      = 6;
    localparam int ENERGY_W    = 53;
    localparam int ENV_W       = 25;
    localparam int GAIN_W      = 25;
    localparam int LOUD_W      = 31;
    localparam int KT_W        = 42;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [LOUD_W-1:0] ONE30      = 31'h4000_0000;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 25'h1FF_FFFF;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 25'h001_0000;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_GAIN_ON      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SMOOTHING    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_COEFF      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_COEFF     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RMS_FLOOR         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOUDNESS_EXPONENT = 3'd5;

    typedef struct packed {
        logic        auto_gain_on;
        logic [15:0] gain_smoothing;
        logic [15:0] attack_coeff;
        logic [15:0] release_coeff;
        logic [23:0] rms_floor;
        logic [15:0] loudness_exponent;
    } t_cfg;

    typedef struct packed {
        logic                start;
        logic [ENERGY_W-1:0] dividend;
        logic [LOUD_W-1:0]   divisor;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [ENERGY_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic                start;
        logic                clear;
        logic [CNT_W-1:0]    count;
        logic [ENERGY_W-1:0] original_energy;
        logic [ENERGY_W-1:0] effect_energy;
    } t_math_req;

    typedef struct packed {
        logic            done;
        logic [KT_W-1:0] gain_step;
    } t_math_rsp;

    typedef logic [15:0][LOUD_W-1:0] t_root_tab;

    // bit-pair integer square root, used at elaboration only
    function automatic logic [63:0] f_isqrt64(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        logic [63:0] t;
        r = '0;
        b = 64'h4000_0000_0000_0000;
        t = v;
        for (int i = 0; i < 32; i++) begin
            if (t >= r + b) begin
                t = t - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // entry k holds 2^(-2^(k-16)) in Q1.30
    function automatic t_root_tab f_root_tab();
        t_root_tab   tab;
        logic [63:0] w;
        w = f_isqrt64(64'h0800_0000_0000_0000);
        tab[15] = w[LOUD_W-1:0];
        for (int k = 14; k >= 0; k--) begin
            w = f_isqrt64({3'b0, tab[k+1], 30'b0});
            tab[k] = w[LOUD_W-1:0];
        end
        return tab;
    endfunction

    localparam t_root_tab ROOT_TAB = f_root_tab();

endpackage

FILE: src/rlmg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmg_in_if
// Input beat channel: paired original and effect samples.
// ----------------------------------------------------------------------------
interface rlmg_in_if;
    import rlmg_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] original_sample;
    logic signed [SAMPLE_BITS-1:0] effect_sample;
    logic                          last_in_block;

    modport source (output valid, original_sample, effect_sample, last_in_block,
                    input ready);
    modport sink   (input valid, original_sample, effect_sample, last_in_block,
                    output ready);
endinterface

FILE: src/rlmg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmg_out_if
// Output beat channel: gain-adjusted samples.
// ----------------------------------------------------------------------------
interface rlmg_out_if;
    import rlmg_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          last_of_run;

    modport source (output valid, out_sample, last_of_run, input ready);
    modport sink   (input valid, out_sample, last_of_run, output ready);
endinterface

FILE: src/rlmg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmg_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rlmg_ram #(
    parameter int  DATA_W = 24,
    parameter int  DEPTH  = 64,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

FILE: src/rlmg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmg_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rlmg_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rlmg_pkg::t_div_req i_req,
    output rlmg_pkg::t_div_rsp o_rsp
);
    import rlmg_pkg::*;

    localparam int STEP_W = $clog2(ENERGY_W);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [ENERGY_W-1:0] r_q;
    logic [LOUD_W-1:0]   r_rem;
    logic [LOUD_W-1:0]   r_dvs;

    logic [LOUD_W:0] shifted;
    logic [LOUD_W:0] diff;
    logic            ge;

    // trial subtract
    always_comb begin
        shifted = {r_rem, r_q[ENERGY_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = shifted >= {1'b0, r_dvs};
    end

    // iterate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_q    <= i_req.dividend;
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[LOUD_W-1:0] : shifted[LOUD_W-1:0];
                r_q   <= {r_q[ENERGY_W-2:0], ge};
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(ENERGY_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
endmodule

FILE: src/rlmg_math.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlmg_math
// Block-end sequencer: RMS, envelopes, loudness power law and target gain.
// ----------------------------------------------------------------------------
module rlmg_math (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rlmg_pkg::t_cfg      i_cfg,
    input  rlmg_pkg::t_math_req i_req,
    output rlmg_pkg::t_math_rsp o_rsp,
    output rlmg_pkg::t_div_req  o_div_req,
    input  rlmg_pkg::t_div_rsp  i_div_rsp
);
    import rlmg_pkg::*;

    typedef enum logic [3:0] {
        M_IDLE, M_DIV, M_SQRT, M_ENV1, M_ENV2, M_LX, M_NORM, M_SQR,
        M_EXP, M_POW, M_SHIFT, M_TDEC, M_TDIV, M_KT
    } t_mstate;

    localparam int SQ_W = 49;

    t_mstate             r_state;
    logic                r_sel;
    logic [4:0]          r_cnt;
    logic                r_div_start;
    logic [ENERGY_W-1:0] r_div_dvd;
    logic [LOUD_W-1:0]   r_div_dvs;
    logic [SQ_W-1:0]     r_sv;
    logic [SQ_W:0]       r_sr;
    logic [SQ_W-1:0]     r_sbit;
    logic [ENV_W-1:0]    r_rms;
    logic [15:0]         r_c;
    logic [40:0]         r_p1;
    logic [ENV_W-1:0]    r_env_o;
    logic [ENV_W-1:0]    r_env_e;
    logic [LOUD_W-1:0]   r_y;
    logic [4:0]          r_k;
    logic [15:0]         r_frac;
    logic [20:0]         r_e;
    logic [LOUD_W-1:0]   r_acc;
    logic [LOUD_W-1:0]   r_lo;
    logic [LOUD_W-1:0]   r_le;
    logic [GAIN_W-1:0]   r_target;
    logic [KT_W-1:0]     r_kt;
    logic                r_done;

    logic [SQ_W:0]           s_try;
    logic                    s_take;
    logic [ENV_W-1:0]        env_cur;
    logic [15:0]             coef;
    logic [42:0]             env_sum;
    logic [ENV_W-1:0]        x_val;
    logic [2*LOUD_W-1:0]     y_sq;
    logic [31:0]             yy;
    logic [20:0]             nl;
    logic [36:0]             nl_p;
    logic [2*LOUD_W-1:0]     acc_mul;
    logic [2*LOUD_W-1:0]     acc_rnd;
    logic [LOUD_W-1:0]       loud;
    logic [4:0]              ie;

    // datapath terms
    always_comb begin
        s_try   = r_sr + {1'b0, r_sbit};
        s_take  = {1'b0, r_sv} >= s_try;
        env_cur = r_sel ? r_env_e : r_env_o;
        coef    = (r_rms > env_cur) ? i_cfg.attack_coeff : i_cfg.release_coeff;
        env_sum = {2'b0, r_p1} + 43'((17'h10000 - {1'b0, r_c}) * r_rms) + 43'd32768;
        x_val   = (env_cur > {1'b0, i_cfg.rms_floor}) ? env_cur : {1'b0, i_cfg.rms_floor};
        y_sq    = r_y * r_y;
        yy      = y_sq[61:30];
        nl      = {5'(5'd24 - r_k), 16'b0} - {5'b0, r_frac};
        nl_p    = nl * i_cfg.loudness_exponent;
        acc_mul = r_acc * ROOT_TAB[r_cnt[3:0]];
        acc_rnd = acc_mul + 62'h2000_0000;
        ie      = r_e[20:16];
        loud    = (ie == 5'd31) ? '0 : (r_acc >> ie);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= M_IDLE;
            r_sel       <= 1'b0;
            r_cnt       <= '0;
            r_div_start <= 1'b0;
            r_env_o     <= '0;
            r_env_e     <= '0;
            r_done      <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
            unique case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_sel       <= 1'b0;
                        r_div_start <= 1'b1;
                        r_div_dvd   <= i_req.original_energy;
                        r_div_dvs   <= {{(LOUD_W-CNT_W){1'b0}}, i_req.count};
                        r_state     <= M_DIV;
                    end
                end
                M_DIV: begin
                    if (i_div_rsp.done) begin
                        r_sv    <= {i_div_rsp.quotient[SQ_W-3:0], 2'b00};
                        r_sr    <= '0;
                        r_sbit  <= {1'b1, {(SQ_W-1){1'b0}}};
                        r_cnt   <= '0;
                        r_state <= M_SQRT;
                    end
                end
                M_SQRT: begin
                    if (s_take) begin
                        r_sv <= r_sv - s_try[SQ_W-1:0];
                        r_sr <= (r_sr >> 1) + {1'b0, r_sbit};
                    end else begin
                        r_sr <= r_sr >> 1;
                    end
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == 5'd24) begin
                        r_rms   <= s_take ? ENV_W'((r_sr >> 1) + {1'b0, r_sbit})
                                          : ENV_W'(r_sr >> 1);
                        r_state <= M_ENV1;
                    end
                end
                M_ENV1: begin
                    r_c     <= coef;
                    r_p1    <= coef * env_cur;
                    r_state <= M_ENV2;
                end
                M_ENV2: begin
                    if (r_sel) begin
                        r_env_e <= env_sum[40:16];
                        r_sel   <= 1'b0;
                        r_state <= M_LX;
                    end else begin
                        r_env_o     <= env_sum[40:16];
                        r_sel       <= 1'b1;
                        r_div_start <= 1'b1;
                        r_div_dvd   <= i_req.effect_energy;
                        r_state     <= M_DIV;
                    end
                end
                M_LX: begin
                    if (x_val == '0) begin
                        r_acc   <= (i_cfg.loudness_exponent == 16'd0) ? ONE30 : '0;
                        r_e     <= '0;
                        r_state <= M_SHIFT;
                    end else begin
                        r_y     <= {x_val, 6'b0};
                        r_k     <= 5'd24;
                        r_state <= M_NORM;
                    end
                end
                M_NORM: begin
                    if (r_y[LOUD_W-1]) begin
                        r_cnt   <= '0;
                        r_frac  <= '0;
                        r_state <= M_SQR;
                    end else begin
                        r_y <= r_y << 1;
                        r_k <= r_k - 1'b1;
                    end
                end
                M_SQR: begin
                    // one fraction bit of -log2 per squaring
                    if (yy[31]) begin
                        r_y    <= yy[31:1];
                        r_frac <= {r_frac[14:0], 1'b1};
                    end else begin
                        r_y    <= yy[30:0];
                        r_frac <= {r_frac[14:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd15) begin
                        r_state <= M_EXP;
                    end
                end
                M_EXP: begin
                    r_e     <= nl_p[36:16];
                    r_acc   <= ONE30;
                    r_cnt   <= '0;
                    r_state <= M_POW;
                end
                M_POW: begin
                    if (r_e[r_cnt[3:0]]) begin
                        r_acc <= acc_rnd[60:30];
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd15) begin
                        r_state <= M_SHIFT;
                    end
                end
                M_SHIFT: begin
                    if (r_sel) begin
                        r_le    <= loud;
                        r_state <= M_TDEC;
                    end else begin
                        r_lo    <= loud;
                        r_sel   <= 1'b1;
                        r_state <= M_LX;
                    end
                end
                M_TDEC: begin
                    if (r_le > {1'b0, i_cfg.rms_floor, 6'b0}) begin
                        r_div_start <= 1'b1;
                        r_div_dvd   <= {6'b0, r_lo, 16'b0};
                        r_div_dvs   <= r_le;
                        r_state     <= M_TDIV;
                    end else begin
                        r_target <= UNITY_GAIN;
                        r_state  <= M_KT;
                    end
                end
                M_TDIV: begin
                    if (i_div_rsp.done) begin
                        r_target <= (i_div_rsp.quotient > {28'b0, GAIN_MAX}) ? GAIN_MAX
                                    : i_div_rsp.quotient[GAIN_W-1:0];
                        r_state  <= M_KT;
                    end
                end
                M_KT: begin
                    r_kt    <= (17'h10000 - {1'b0, i_cfg.gain_smoothing}) * r_target;
                    r_done  <= 1'b1;
                    r_state <= M_IDLE;
                end
                default: r_state <= M_IDLE;
            endcase
            // drop envelopes on bypass
            if (i_req.clear) begin
                r_env_o <= '0;
                r_env_e <= '0;
            end
        end
    end

    assign o_div_req.start    = r_div_start;
    assign o_div_req.dividend = r_div_dvd;
    assign o_div_req.divisor  = r_div_dvs;
    assign o_rsp.done         = r_done;
    assign o_rsp.gain_step    = r_kt;
endmodule

FILE: src/rms_loudness_match_gain_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_loudness_match_gain_top
// Loudness matching automatic gain over blocks of buffered effect samples.
// ----------------------------------------------------------------------------
// With auto gain on, a beat is accepted in S_IN and accumulated in S_ACC
// before the next beat is accepted. At a block end the math sequencer
// runs two divisions and 25-step square roots for the RMS values,
// normalize, squaring and root-table products for each loudness, and,
// if the effect loudness is above the floor, a division for the target
// gain, all on one shared divider.
// The block then emits its buffered samples one by one through the
// S_RD, S_MUL and S_OUT states, read back from the sample RAM one per
// read-port access. In bypass, one beat passes per cycle while the output is free.
// ----------------------------------------------------------------------------
module rms_loudness_match_gain_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rlmg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rlmg_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    rlmg_in_if.sink                            i_in,
    rlmg_out_if.source                         o_out
);
    import rlmg_pkg::*;

    typedef enum logic [2:0] {S_IN, S_ACC, S_MATH, S_RD, S_MUL, S_OUT} t_state;

    t_state                        r_state;
    t_cfg                          r_cfg;
    logic [CNT_W-1:0]              r_count;
    logic [ADDR_W-1:0]             r_idx;
    logic [ENERGY_W-1:0]           r_orig_e;
    logic [ENERGY_W-1:0]           r_eff_e;
    logic [GAIN_W-1:0]             r_gain;
    logic signed [SAMPLE_BITS-1:0] r_smp_o;
    logic signed [SAMPLE_BITS-1:0] r_smp_e;
    logic                          r_smp_last;
    logic signed [49:0]            r_prod;
    logic                          r_math_start;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample;
    logic                          r_out_last;

    t_math_req math_req;
    t_math_rsp math_rsp;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    logic                          in_fire;
    logic                          out_free;
    logic                          out_load;
    logic signed [SAMPLE_BITS-1:0] n_out_sample;
    logic                          n_out_last;
    logic signed [47:0]            sq_o;
    logic signed [47:0]            sq_e;
    logic [CNT_W-1:0]              count_inc;
    logic                          blk_end;
    logic                          idx_last;
    logic [42:0]                   gain_sum;
    logic [GAIN_W-1:0]             n_gain;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [49:0]            n_prod;
    logic signed [49:0]            rnd_full;
    logic signed [33:0]            rnd;
    logic signed [SAMPLE_BITS-1:0] sat_sample;
    logic                          clear_run;

    // handshake
    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IN) && (r_cfg.auto_gain_on || out_free);
    assign in_fire    = i_in.valid && i_in.ready;
    assign clear_run  = i_cfg_we && (i_cfg_idx == CFG_AUTO_GAIN_ON) && !i_cfg_data[0];

    // accumulate and emit datapath
    always_comb begin
        sq_o      = r_smp_o * r_smp_o;
        sq_e      = r_smp_e * r_smp_e;
        count_inc = r_count + 1'b1;
        blk_end   = r_smp_last || (count_inc == CNT_W'(BLOCK_MAX));
        idx_last  = ({1'b0, r_idx} + 1'b1) == r_count;
        gain_sum  = 43'(r_cfg.gain_smoothing * r_gain) + {1'b0, math_rsp.gain_step}
                    + 43'd32768;
        n_gain    = gain_sum[40:16];
        n_prod    = $signed(ram_rdata) * $signed({1'b0, r_gain});
        rnd_full  = r_prod + 50'sd32768;
        rnd       = rnd_full[49:16];
        if (rnd > 34'sd8388607) begin
            sat_sample = 24'sh7F_FFFF;
        end else if (rnd < -34'sd8388608) begin
            sat_sample = -24'sh80_0000;
        end else begin
            sat_sample = rnd[SAMPLE_BITS-1:0];
        end
        out_load     = (in_fire && !r_cfg.auto_gain_on) || ((r_state == S_OUT) && out_free);
        n_out_sample = (r_state == S_OUT) ? sat_sample : i_in.effect_sample;
        n_out_last   = (r_state == S_OUT) ? idx_last : i_in.last_in_block;
    end

    // control and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                 <= S_IN;
            r_cfg.auto_gain_on      <= 1'b1;
            r_cfg.gain_smoothing    <= 16'd65208;
            r_cfg.attack_coeff      <= 16'd0;
            r_cfg.release_coeff     <= 16'd65503;
            r_cfg.rms_floor         <= 24'd1678;
            r_cfg.loudness_exponent <= 16'd42598;
            r_count                 <= '0;
            r_idx                   <= '0;
            r_orig_e                <= '0;
            r_eff_e                 <= '0;
            r_gain                  <= UNITY_GAIN;
            r_math_start            <= 1'b0;
            r_out_valid             <= 1'b0;
        end else begin
            r_math_start <= 1'b0;
            // output register
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_sample <= n_out_sample;
                r_out_last   <= n_out_last;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IN: begin
                    if (in_fire && r_cfg.auto_gain_on) begin
                        r_smp_o    <= i_in.original_sample;
                        r_smp_e    <= i_in.effect_sample;
                        r_smp_last <= i_in.last_in_block;
                        r_state    <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_orig_e <= r_orig_e + {6'b0, sq_o[46:0]};
                    r_eff_e  <= r_eff_e + {6'b0, sq_e[46:0]};
                    r_count  <= count_inc;
                    if (blk_end) begin
                        r_math_start <= 1'b1;
                        r_idx        <= '0;
                        r_state      <= S_MATH;
                    end else begin
                        r_state <= S_IN;
                    end
                end
                S_MATH: begin
                    if (math_rsp.done) begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_gain  <= n_gain;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= n_prod;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_idx <= r_idx + 1'b1;
                        if (idx_last) begin
                            r_count  <= '0;
                            r_orig_e <= '0;
                            r_eff_e  <= '0;
                            r_state  <= S_IN;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IN;
            endcase
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_AUTO_GAIN_ON:      r_cfg.auto_gain_on      <= i_cfg_data[0];
                    CFG_GAIN_SMOOTHING:    r_cfg.gain_smoothing    <= i_cfg_data[15:0];
                    CFG_ATTACK_COEFF:      r_cfg.attack_coeff      <= i_cfg_data[15:0];
                    CFG_RELEASE_COEFF:     r_cfg.release_coeff     <= i_cfg_data[15:0];
                    CFG_RMS_FLOOR:         r_cfg.rms_floor         <= i_cfg_data[23:0];
                    CFG_LOUDNESS_EXPONENT: r_cfg.loudness_exponent <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // drop a partial block and gain state on bypass
            if (clear_run) begin
                r_count  <= '0;
                r_orig_e <= '0;
                r_eff_e  <= '0;
                r_gain   <= UNITY_GAIN;
            end
        end
    end

    assign math_req.start           = r_math_start;
    assign math_req.clear           = clear_run;
    assign math_req.count           = r_count;
    assign math_req.original_energy = r_orig_e;
    assign math_req.effect_energy   = r_eff_e;

    rlmg_ram #(
        .DATA_W (SAMPLE_BITS),
        .DEPTH  (BLOCK_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (r_state == S_ACC),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (r_smp_e),
        .i_re    (r_state == S_RD),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    rlmg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    rlmg_math u_math (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_req     (math_req),
        .o_rsp     (math_rsp),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp)
    );

    assign o_out.valid       = r_out_valid;
    assign o_out.out_sample  = r_out_sample;
    assign o_out.last_of_run = r_out_last;

    // checks
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(BLOCK_MAX))
        else $error("block count above buffer depth");

    a_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gain <= GAIN_MAX)
        else $error("smoothed gain above saturation");

    a_done_in_math: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        math_rsp.done |-> (r_state == S_MATH))
        else $error("block-end math finished outside its wait state");

    a_emit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> ({1'b0, r_idx} < r_count))
        else $error("emit index past block length");

    a_bypass_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !r_cfg.auto_gain_on) |=> r_out_valid)
        else $error("bypass beat did not reach the output register");
endmodule

FILE: tb/sv/rms_loudness_match_gain_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rms_loudness_match_gain_top_tb
// Self-checking bench for the loudness matching gain block. A directed
// stimulus table covers sample extremes, silence, bypass and a block that
// is dropped by disabling mid-block. Random blocks follow under several
// register settings. Every output beat is compared with a built-in
// fixed-point model of the block-end RMS, envelope, power-law loudness
// and per-sample smoothed gain.
// ----------------------------------------------------------------------------
module rms_loudness_match_gain_top_tb;
    import rlmg_pkg::*;

    localparam longint unsigned Q30 = 64'd1 << 30;
    localparam int SETTLE_CYCLES = 400;
    localparam int SMAX = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SMIN = -(1 << (SAMPLE_BITS - 1));

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } gain_beat_t;

    typedef struct {
        logic                          bypass;
        logic                          typed;
        logic signed [SAMPLE_BITS-1:0] orig;
        logic signed [SAMPLE_BITS-1:0] eff;
        logic                          last;
    } stim_row_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rlmg_in_if  in_ch ();
    rlmg_out_if out_ch ();

    rms_loudness_match_gain_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // model copy of registers and gain state
    logic        m_auto_on;
    logic [15:0] m_smooth;
    logic [15:0] m_attack;
    logic [15:0] m_release;
    logic [23:0] m_floor;
    logic [15:0] m_expo;

    longint          held_eff [BLOCK_MAX];
    int              fill_cnt;
    longint unsigned orig_pow_sum;
    longint unsigned eff_pow_sum;
    longint unsigned orig_env;
    longint unsigned eff_env;
    longint unsigned gain_q16;
    longint unsigned root2_tab [16];

    gain_beat_t gain_out_q [$];
    int         mismatch_cnt;
    int         send_idle_pct;
    int         recv_stall_pct;

    stim_row_t dir_tab [14] = '{
        '{1'b0, 1'b0, SMAX,       SMAX,       1'b1},
        '{1'b0, 1'b0, SMIN,       SMIN,       1'b1},
        '{1'b0, 1'b0, 0,          0,          1'b1},
        '{1'b0, 1'b0, SMAX,       1,          1'b1},
        '{1'b0, 1'b0, 1,          SMAX,       1'b0},
        '{1'b0, 1'b0, SMIN,       -1,         1'b0},
        '{1'b0, 1'b0, 12345,      -12345,     1'b1},
        '{1'b0, 1'b0, 24'h400000, SMAX,       1'b0},
        '{1'b1, 1'b1, 0,          SMAX,       1'b1},
        '{1'b1, 1'b1, SMAX,       SMIN,       1'b0},
        '{1'b1, 1'b1, -1,         0,          1'b1},
        '{1'b1, 1'b1, SMIN,       24'h555555, 1'b0},
        '{1'b0, 1'b0, 24'h2AAAAA, 24'hD55556, 1'b0},
        '{1'b0, 1'b0, 24'h12A5F0, 24'hAAAAAA, 1'b1}
    };

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // x^p in Q1.30 via log2 by repeated squaring and root-of-two products
    function automatic longint unsigned loud_pow(input longint unsigned x,
                                                 input logic [15:0] p);
        int              msb;
        longint unsigned y;
        longint unsigned fr;
        longint unsigned nl;
        longint unsigned ex;
        longint unsigned acc;
        if (x == 0) return (p == 0) ? Q30 : 0;
        msb = 0;
        for (int i = 0; i < 64; i++) if (x[i]) msb = i;
        if (msb > 24) return Q30;
        y  = x << (30 - msb);
        fr = 0;
        for (int i = 0; i < 16; i++) begin
            y  = (y * y) >> 30;
            fr = fr << 1;
            if (y >= (Q30 << 1)) begin
                fr = fr | 1;
                y  = y >> 1;
            end
        end
        nl  = longint'(24 - msb) * 65536 - fr;
        ex  = (nl * longint'(p)) >> 16;
        acc = Q30;
        for (int i = 0; i < 16; i++)
            if (ex[i]) acc = (acc * root2_tab[i] + (Q30 >> 1)) >> 30;
        if ((ex >> 16) >= 31) return 0;
        return acc >> (ex >> 16);
    endfunction

    function automatic longint unsigned env_step(input longint unsigned env,
                                                 input longint unsigned rms);
        longint unsigned c;
        c = (rms > env) ? longint'(m_attack) : longint'(m_release);
        return (c * env + (65536 - c) * rms + 32768) >> 16;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(input longint prod);
        longint r;
        if (prod >= 0) r = (prod + 32768) >>> 16;
        else r = -((-prod + 32767) >>> 16);
        if (r > SMAX) r = SMAX;
        if (r < SMIN) r = SMIN;
        return r[SAMPLE_BITS-1:0];
    endfunction

    task automatic clear_gain_state();
        gain_q16     = 65536;
        orig_env     = 0;
        eff_env      = 0;
        fill_cnt     = 0;
        orig_pow_sum = 0;
        eff_pow_sum  = 0;
    endtask

    // fold one accepted beat into the model, queue any outputs it releases
    task automatic predict_gain_beat(input logic signed [SAMPLE_BITS-1:0] o,
                                     input logic signed [SAMPLE_BITS-1:0] e,
                                     input logic l);
        longint          ov;
        longint          ev;
        longint unsigned rms_o;
        longint unsigned rms_e;
        longint unsigned xo;
        longint unsigned xe;
        longint unsigned lo;
        longint unsigned le;
        longint unsigned target;
        longint unsigned s;
        gain_beat_t      b;
        ov = o;
        ev = e;
        if (!m_auto_on) begin
            clear_gain_state();
            b.sample = e;
            b.last   = l;
            gain_out_q.push_back(b);
            return;
        end
        if (fill_cnt >= BLOCK_MAX) fill_cnt = 0;
        held_eff[fill_cnt] = ev;
        orig_pow_sum += longint'(ov * ov);
        eff_pow_sum  += longint'(ev * ev);
        fill_cnt++;
        if (!l && fill_cnt < BLOCK_MAX) return;

        rms_o    = int_sqrt((orig_pow_sum / fill_cnt) << 2);
        rms_e    = int_sqrt((eff_pow_sum / fill_cnt) << 2);
        orig_env = env_step(orig_env, rms_o);
        eff_env  = env_step(eff_env, rms_e);
        xo = (orig_env > m_floor) ? orig_env : longint'(m_floor);
        xe = (eff_env > m_floor) ? eff_env : longint'(m_floor);
        lo = loud_pow(xo, m_expo);
        le = loud_pow(xe, m_expo);
        target = 65536;
        if (le > (longint'(m_floor) << 6)) begin
            target = (lo << 16) / le;
            if (target > GAIN_MAX) target = GAIN_MAX;
        end
        s = m_smooth;
        for (int k = 0; k < fill_cnt; k++) begin
            gain_q16 = (s * gain_q16 + (65536 - s) * target + 32768) >> 16;
            b.sample = scale_sat(held_eff[k] * longint'(gain_q16));
            b.last   = (k + 1 == fill_cnt);
            gain_out_q.push_back(b);
        end
        fill_cnt     = 0;
        orig_pow_sum = 0;
        eff_pow_sum  = 0;
    endtask

    // wait for the block to drain, then let any block-end math finish
    task automatic wait_idle();
        while (gain_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_AUTO_GAIN_ON: begin
                m_auto_on = val[0];
                if (!m_auto_on) clear_gain_state();
            end
            CFG_GAIN_SMOOTHING:    m_smooth  = val[15:0];
            CFG_ATTACK_COEFF:      m_attack  = val[15:0];
            CFG_RELEASE_COEFF:     m_release = val[15:0];
            CFG_RMS_FLOOR:         m_floor   = val[23:0];
            CFG_LOUDNESS_EXPONENT: m_expo    = val[15:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(input int unsigned on, input int unsigned sm,
                             input int unsigned at, input int unsigned rl,
                             input int unsigned fl, input int unsigned ex);
        write_reg(CFG_AUTO_GAIN_ON, on);
        write_reg(CFG_GAIN_SMOOTHING, sm);
        write_reg(CFG_ATTACK_COEFF, at);
        write_reg(CFG_RELEASE_COEFF, rl);
        write_reg(CFG_RMS_FLOOR, fl);
        write_reg(CFG_LOUDNESS_EXPONENT, ex);
    endtask

    // present one beat and hold it until accepted; typed rows carry their own
    task automatic send_beat(input logic signed [SAMPLE_BITS-1:0] o,
                             input logic signed [SAMPLE_BITS-1:0] e,
                             input logic l, input logic typed);
        gain_beat_t b;
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid           <= 1'b1;
        in_ch.original_sample <= o;
        in_ch.effect_sample   <= e;
        in_ch.last_in_block   <= l;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (typed) begin
            b.sample = e;
            b.last   = l;
            gain_out_q.push_back(b);
        end else begin
            predict_gain_beat(o, e, l);
        end
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        logic signed [SAMPLE_BITS-1:0] v;
        v = $urandom();
        return v >>> $urandom_range(0, SAMPLE_BITS - 1);
    endfunction

    // random traffic: mostly well-formed blocks, some full-buffer runs and noise
    task automatic send_random(input int n_beats);
        int sent;
        int len;
        int kind;
        sent = 0;
        while (sent < n_beats) begin
            if (!m_auto_on) begin
                send_beat($urandom(), $urandom(), $urandom_range(1), 1'b0);
                sent++;
            end else begin
                kind = $urandom_range(9);
                if (kind == 0) begin
                    send_beat($urandom(), $urandom(), $urandom_range(1), 1'b0);
                    sent++;
                end else begin
                    len = (kind == 1) ? $urandom_range(BLOCK_MAX, BLOCK_MAX + 6)
                                      : $urandom_range(1, 12);
                    for (int k = 0; k < len; k++)
                        send_beat(rand_sample(), rand_sample(),
                                  (kind != 1) && (k == len - 1), 1'b0);
                    sent += len;
                end
            end
        end
    endtask

    // accept output beats and check against the oldest prediction
    always @(posedge i_clk) begin
        gain_beat_t want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (gain_out_q.size() == 0) begin
                $display("%0t: unexpected output beat sample %0d last %0b", $time,
                         out_ch.out_sample, out_ch.last_of_run);
                mismatch_cnt++;
            end else begin
                want = gain_out_q.pop_front();
                if (out_ch.out_sample !== want.sample) begin
                    $display("%0t: out_sample expected %0d actual %0d", $time,
                             want.sample, out_ch.out_sample);
                    mismatch_cnt++;
                end
                if (out_ch.last_of_run !== want.last) begin
                    $display("%0t: last_of_run expected %0b actual %0b", $time,
                             want.last, out_ch.last_of_run);
                    mismatch_cnt++;
                end
            end
        end
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // hard stop
    initial begin
        #8ms;
        $display("rms_loudness_match_gain_top: mismatch");
        $finish;
    end

    initial begin
        logic cur_bypass;
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = '0;
        i_cfg_data            = '0;
        in_ch.valid           = 1'b0;
        in_ch.original_sample = '0;
        in_ch.effect_sample   = '0;
        in_ch.last_in_block   = 1'b0;
        out_ch.ready          = 1'b0;
        mismatch_cnt          = 0;
        send_idle_pct         = 16;
        recv_stall_pct        = 58;

        root2_tab[15] = int_sqrt((Q30 >> 1) << 30);
        for (int k = 14; k >= 0; k--) root2_tab[k] = int_sqrt(root2_tab[k+1] << 30);
        m_auto_on = 1'b1;
        m_smooth  = 16'd65208;
        m_attack  = 16'd0;
        m_release = 16'd65503;
        m_floor   = 24'd1678;
        m_expo    = 16'd42598;
        clear_gain_state();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table; a mode change drains and toggles auto gain, which
        // also drops the partial block left before the bypass rows
        cur_bypass = 1'b0;
        foreach (dir_tab[r]) begin
            if (dir_tab[r].bypass != cur_bypass) begin
                in_ch.valid <= 1'b0;
                wait_idle();
                write_reg(CFG_AUTO_GAIN_ON, !dir_tab[r].bypass);
                cur_bypass = dir_tab[r].bypass;
            end
            send_beat(dir_tab[r].orig, dir_tab[r].eff, dir_tab[r].last, dir_tab[r].typed);
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < 6; ph++) begin
            in_ch.valid <= 1'b0;
            wait_idle();
            if (ph == 2) begin
                send_idle_pct  = 58;
                recv_stall_pct = 16;
            end else if (ph == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            case (ph)
                0: write_all(1, 65208, 0, 65503, 1678, 42598);
                1: write_all(1, 0, 0, 0, 0, 0);
                2: write_all(1, 65535, 65535, 65535, 24'hFFFFFF, 65535);
                3: write_all(0, $urandom_range(65535), $urandom_range(65535),
                             $urandom_range(65535), $urandom_range(24'hFFFFFF),
                             $urandom_range(65535));
                default: write_all(1, $urandom_range(40000, 65535),
                                   $urandom_range(65535), $urandom_range(65535),
                                   $urandom_range(4000), $urandom_range(65535));
            endcase
            send_random(78);
        end
        in_ch.valid <= 1'b0;

        while (gain_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0) begin
            $display("rms_loudness_match_gain_top: match");
        end else begin
            $display("rms_loudness_match_gain_top: mismatch");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/rlmg_pkg.sv
src/rlmg_in_if.sv
src/rlmg_out_if.sv
src/rlmg_ram.sv
src/rlmg_div.sv
src/rlmg_math.sv
src/rms_loudness_match_gain_top.sv
tb/sv/rms_loudness_match_gain_top_tb.sv
